@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// condition must never be seen outside reset
`define CHK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ src/fppa_pkg.sv @@
// shared constants, codes and types of the page pool allocator
package fppa_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int ADDR_W    = 32;
  localparam int IDX_W     = $clog2(MAX_PAGES);
  localparam int CNT_W     = $clog2(MAX_PAGES + 1);
  localparam int SIZE_W    = 24;
  localparam int PCOUNT_W  = 11;
  localparam int AVAIL_W   = 11;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd2;

  localparam logic [SIZE_W-1:0]   PAGE_SIZE_RST  = 24'd64;
  localparam logic [PCOUNT_W-1:0] PAGE_COUNT_RST = 11'd1024;

  typedef enum logic [KIND_W-1:0] {
    K_ALLOC  = 2'd0,
    K_FREE   = 2'd1,
    K_CREATE = 2'd2,
    K_DELETE = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_UNREADY     = 3'd1,
    ST_NO_MEM      = 3'd2,
    ST_POOL_FULL   = 3'd3,
    ST_BAD_ADDR    = 3'd4,
    ST_DOUBLE_FREE = 3'd5,
    ST_FAULT       = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_MUL,
    S_ALLOC_ADD,
    S_DIV,
    S_MAP_RD,
    S_FREE_CHK
  } state_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quot;
    logic [SIZE_W-1:0] rem;
  } div_rsp_t;

endpackage

@@ src/fppa_div.sv @@
// restoring divider, one quotient bit per cycle
module fppa_div (
  input  logic               clk,
  input  logic               rst_n,
  input  fppa_pkg::div_req_t req,
  output fppa_pkg::div_rsp_t rsp
);
  import fppa_pkg::*;

  localparam int STEP_W = $clog2(ADDR_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] quo_r, quo_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W-1:0] dvs_r, dvs_nxt;
  logic [SIZE_W:0]   rem_sh;
  logic [SIZE_W:0]   diff;
  logic              fits;

  always_comb begin
    rem_sh   = {rem_r, quo_r[ADDR_W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    fits     = (rem_sh >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(ADDR_W);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
      quo_nxt = {quo_r[ADDR_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

@@ src/fixed_page_pool_allocator.sv @@
// fixed page pool allocator: command channel, pool state in two memories
// create, delete and items rejected on entry answer in the cycle after acceptance;
//   alloc passes a queue read state (free queue only), then multiply and add states;
//   a free passes the 32-step serial divider, map read and free check; one item at a time
// reset: synchronous active low; pool not ready, counts and pointers zero,
//   config registers back to base 0, page size 64, page count 1024
// results come as a one-cycle strobe, the receiver cannot stall them
module fixed_page_pool_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [fppa_pkg::KIND_W-1:0]       in_kind,
  input  logic [fppa_pkg::ADDR_W-1:0]       in_addr,
  // result channel
  output logic                              out_valid,
  output logic [fppa_pkg::STATUS_W-1:0]     out_status,
  output logic [fppa_pkg::ADDR_W-1:0]       out_page_addr,
  output logic [fppa_pkg::AVAIL_W-1:0]      out_pages_avail,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [fppa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fppa_pkg::CFG_W-1:0]        cfg_wdata
);
  import fppa_pkg::*;

  // configuration registers, copied into the pool at create
  logic [ADDR_W-1:0]   pool_base_r;
  logic [SIZE_W-1:0]   page_size_r;
  logic [PCOUNT_W-1:0] page_count_r;

  // latched pool geometry
  logic [ADDR_W-1:0] lat_base_r, lat_base_nxt;
  logic [SIZE_W-1:0] lat_size_r, lat_size_nxt;
  logic [CNT_W-1:0]  lat_count_r, lat_count_nxt;

  // pool control state
  state_t           state_r, state_nxt;
  logic             ready_r, ready_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] fresh_r, fresh_nxt;
  logic [CNT_W-1:0] avail_r, avail_nxt;

  // per-item working registers
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0] prod_r, prod_nxt;

  // result registers
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_page_addr_r, out_page_addr_nxt;
  logic [AVAIL_W-1:0] out_pages_avail_r, out_pages_avail_nxt;

  // free queue memory: page indexes in the order they were freed
  logic [IDX_W-1:0] q_mem [MAX_PAGES];
  logic [IDX_W-1:0] q_rd_r;
  logic             q_we;

  // free map memory; entries at or above the fresh count were never handed
  // out since create and read as free without being stored
  logic             map_mem [MAX_PAGES];
  logic             map_rd_r;
  logic             map_we;
  logic             map_wdata;
  logic             page_is_free;

  // divider for the page index of a free
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic accept;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] p);
    next_slot = (p == IDX_W'(MAX_PAGES - 1)) ? '0 : p + 1'b1;
  endfunction

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  fppa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // config writes; an index past the list is taken and dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r  <= '0;
      page_size_r  <= PAGE_SIZE_RST;
      page_count_r <= PAGE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_BASE:  pool_base_r  <= cfg_wdata[ADDR_W-1:0];
        CFG_PAGE_SIZE:  page_size_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_PAGE_COUNT: page_count_r <= cfg_wdata[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign page_is_free = ({1'b0, idx_r} >= fresh_r) ? 1'b1 : map_rd_r;

  always_comb begin
    state_nxt     = state_r;
    ready_nxt     = ready_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fresh_nxt     = fresh_r;
    avail_nxt     = avail_r;
    lat_base_nxt  = lat_base_r;
    lat_size_nxt  = lat_size_r;
    lat_count_nxt = lat_count_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;

    out_valid_nxt     = 1'b0;
    out_status_nxt    = ST_OK;
    out_page_addr_nxt = '0;

    q_we      = 1'b0;
    map_we    = 1'b0;
    map_wdata = 1'b0;

    div_req.start    = 1'b0;
    div_req.dividend = in_addr - lat_base_r;
    div_req.divisor  = lat_size_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (kind_t'(in_kind))
            K_CREATE: begin
              out_valid_nxt = 1'b1;
              if (ready_r) begin
                out_status_nxt = ST_FAULT;
              end else begin
                lat_base_nxt = pool_base_r;
                lat_size_nxt = page_size_r;
                if (32'(page_count_r) > 32'(MAX_PAGES)) begin
                  lat_count_nxt = CNT_W'(MAX_PAGES);
                end else begin
                  lat_count_nxt = CNT_W'(page_count_r);
                end
                // resetting the fresh count marks every page free
                fresh_nxt = '0;
                head_nxt  = '0;
                tail_nxt  = '0;
                avail_nxt = lat_count_nxt;
                ready_nxt = 1'b1;
              end
            end
            K_DELETE: begin
              out_valid_nxt = 1'b1;
              if (!ready_r) begin
                out_status_nxt = ST_UNREADY;
              end else begin
                ready_nxt = 1'b0;
                avail_nxt = '0;
                fresh_nxt = '0;
                head_nxt  = '0;
                tail_nxt  = '0;
              end
            end
            K_ALLOC: begin
              if (!ready_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_UNREADY;
              end else if (avail_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_NO_MEM;
              end else begin
                avail_nxt = avail_r - 1'b1;
                if (fresh_r < lat_count_r) begin
                  // never handed out yet, take the next one in index order
                  idx_nxt   = fresh_r[IDX_W-1:0];
                  fresh_nxt = fresh_r + 1'b1;
                  state_nxt = S_ALLOC_MUL;
                end else begin
                  // queue head is read this cycle, data next cycle
                  head_nxt  = next_slot(head_r);
                  state_nxt = S_ALLOC_RD;
                end
              end
            end
            K_FREE: begin
              if (!ready_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_UNREADY;
              end else if (avail_r >= lat_count_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_POOL_FULL;
              end else if (lat_size_r == '0 || in_addr < lat_base_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_BAD_ADDR;
              end else begin
                div_req.start = 1'b1;
                state_nxt     = S_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      S_ALLOC_RD: begin
        idx_nxt   = q_rd_r;
        state_nxt = S_ALLOC_MUL;
      end
      S_ALLOC_MUL: begin
        // page now out: clear its free bit
        map_we    = 1'b1;
        map_wdata = 1'b0;
        prod_nxt  = ADDR_W'(idx_r) * ADDR_W'(lat_size_r);
        state_nxt = S_ALLOC_ADD;
      end
      S_ALLOC_ADD: begin
        out_valid_nxt     = 1'b1;
        out_page_addr_nxt = lat_base_r + prod_r;
        state_nxt         = S_IDLE;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quot >= ADDR_W'(lat_count_r) || div_rsp.rem != '0) begin
            // past the last page or not on a page start
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_BAD_ADDR;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt   = div_rsp.quot[IDX_W-1:0];
            state_nxt = S_MAP_RD;
          end
        end
      end
      S_MAP_RD: begin
        // map entry at idx_r is read at the end of this cycle
        state_nxt = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (page_is_free) begin
          out_status_nxt = ST_DOUBLE_FREE;
        end else begin
          q_we      = 1'b1;
          tail_nxt  = next_slot(tail_r);
          map_we    = 1'b1;
          map_wdata = 1'b1;
          avail_nxt = avail_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_pages_avail_nxt = AVAIL_W'(avail_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_r     <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      fresh_r     <= '0;
      avail_r     <= '0;
      lat_base_r  <= '0;
      lat_size_r  <= '0;
      lat_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fresh_r     <= fresh_nxt;
      avail_r     <= avail_nxt;
      lat_base_r  <= lat_base_nxt;
      lat_size_r  <= lat_size_nxt;
      lat_count_r <= lat_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r             <= idx_nxt;
    prod_r            <= prod_nxt;
    out_status_r      <= out_status_nxt;
    out_page_addr_r   <= out_page_addr_nxt;
    out_pages_avail_r <= out_pages_avail_nxt;
  end

  // free queue: write at tail on a good free, read at head every cycle
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[tail_r] <= idx_r;
    end
    q_rd_r <= q_mem[head_r];
  end

  // free map: written and read at the current page index
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[idx_r] <= map_wdata;
    end
    map_rd_r <= map_mem[idx_r];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_page_addr   = out_page_addr_r;
  assign out_pages_avail = out_pages_avail_r;

endmodule

@@ src/fppa_checker.sv @@
// port-level checker for the page pool allocator, bound to the top level
`include "assert_macros.svh"

module fppa_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [fppa_pkg::KIND_W-1:0]       in_kind,
  input logic [fppa_pkg::ADDR_W-1:0]       in_addr,
  input logic                              out_valid,
  input logic [fppa_pkg::STATUS_W-1:0]     out_status,
  input logic [fppa_pkg::ADDR_W-1:0]       out_page_addr,
  input logic [fppa_pkg::AVAIL_W-1:0]      out_pages_avail,
  input logic                              cfg_we,
  input logic [fppa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [fppa_pkg::CFG_W-1:0]        cfg_wdata
);
  import fppa_pkg::*;

  // an accepted command either goes busy or answers at once
  `CHK_ASSERT(a_accept_moves, start && !busy |=> busy || out_valid, "accepted command lost")

  // end of a multi-cycle command always brings its result
  `CHK_ASSERT(a_done_strobes, $fell(busy) |-> out_valid, "busy fell without a result")

  // no result transfer while a command is still at work
  `CHK_NEVER(a_no_strobe_busy, busy && out_valid, "result strobe while busy")

  // only a successful alloc carries a page address
  `CHK_ASSERT(a_addr_on_ok, out_valid && out_status != ST_OK |-> out_page_addr == '0, "page address on failure")

endmodule

bind fixed_page_pool_allocator fppa_checker u_fppa_checker (.*);
